[hw/rtl/gtg_pkg.sv]
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared widths, tables, codes and controller/datapath interface types for the
// go-to-goal steering step.
// ----------------------------------------------------------------------------
package gtg_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);

   localparam int POS_W      = 16;
   localparam int DIFF_W     = 17;
   localparam int PROD_W     = 34;
   localparam int ACC_W      = 36;
   localparam int CW         = 45;
   localparam int ZW         = 26;
   localparam int ANG_W      = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CMD_W      = 2;
   localparam int TURN_W     = 10;
   localparam int DUR_W      = 17;

   // arctangent of 2^-i in degrees, 16 fraction bits
   localparam logic [21:0] ATAN_Q16 [24] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
      22'd234379,  22'd117304,  22'd58666,  22'd29335,
      22'd14668,   22'd7334,    22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,
      22'd57,      22'd29,      22'd14,     22'd7,
      22'd4,       22'd2,       22'd1,      22'd0
   };

   localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 * 65536);

   typedef enum logic [CMD_W-1:0] {
      OUT_FWD   = 2'd0,
      OUT_LEFT  = 2'd1,
      OUT_RIGHT = 2'd2,
      OUT_HALT  = 2'd3
   } out_cmd_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_MXMX,
      MUL_MYMY,
      MUL_HMHM,
      MUL_TXTX,
      MUL_TYTY,
      MUL_ADAD,
      MUL_HXTY,
      MUL_HYTX,
      MUL_HXTX,
      MUL_HYTY,
      MUL_ARRIVE,
      MUL_STEP,
      MUL_TURN
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_FWD,
      RES_TURN,
      RES_ARRIVE,
      RES_HALT
   } res_op_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_RUN,
      PH_HALT
   } phase_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FIRST,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_M5,
      ST_M6,
      ST_ARR,
      ST_X1,
      ST_X2,
      ST_X3,
      ST_X4,
      ST_CLOAD,
      ST_NORM,
      ST_QUAD,
      ST_ITER,
      ST_ANGLE,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               capture;
      mul_sel_type        mul_sel;
      acc_op_type         acc_op;
      logic               heading_move;
      logic               heading_tgt;
      logic               cross_save;
      logic               c_load;
      logic               c_norm;
      logic               c_quad;
      logic               c_iter;
      logic [ITER_W-1:0]  iter;
      logic               angle_save;
      res_op_type         res_op;
      logic               out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic far;
      logic near;
      logic vec_zero;
      logic norm_done;
      logic turn_req;
   } dp_sts_type;

endpackage

[hw/rtl/go_to_goal_steering_step.sv]
// ----------------------------------------------------------------------------
// go_to_goal_steering_step
// Go-to-goal steering: one position fix in, one motion command out.
//
// req_* carries a position fix (cm); rsp_* returns command, turn angle,
// duration in ms and the arrival flag. Both use valid/ready. csr_* writes
// the eight setup registers; write them only while the block is idle.
// One item is processed at a time; req_ready is high only while idle.
// From accept to rsp_valid: a halted fix goes straight to the result, the
// first fix computes only the step duration, and otherwise one shared
// 17x17 multiplier runs the distance and, unless arrived, the cross/dot
// products; a zero angle vector then skips the CORDIC, else the normalize
// shift runs and the CORDIC unit takes one step per cycle (16 steps).
// The result sits in an output register; the next fix is accepted as soon
// as the result is loaded, and only a further result waits on rsp_ready.
// Reset restores the register defaults, clears position and heading, and
// returns to waiting for the first fix.
// ----------------------------------------------------------------------------
module go_to_goal_steering_step (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [gtg_pkg::POS_W-1:0]       req_fix_x,
   input  logic signed [gtg_pkg::POS_W-1:0]       req_fix_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [gtg_pkg::CMD_W-1:0]              rsp_command,
   output logic signed [gtg_pkg::TURN_W-1:0]      rsp_turn_degrees,
   output logic [gtg_pkg::DUR_W-1:0]              rsp_duration_ms,
   output logic                                   rsp_arrived,
   input  logic                                   csr_wr_en,
   input  logic [gtg_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   gtg_pkg::dp_cmd_type cmd;
   gtg_pkg::dp_sts_type sts;

   gtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gtg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_fix_x        (req_fix_x),
      .req_fix_y        (req_fix_y),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_command      (rsp_command),
      .rsp_turn_degrees (rsp_turn_degrees),
      .rsp_duration_ms  (rsp_duration_ms),
      .rsp_arrived      (rsp_arrived)
   );

endmodule

[hw/rtl/gtg_dp.sv]
// ----------------------------------------------------------------------------
// gtg_dp
// Datapath: config registers, position and heading state, shared multiplier
// with accumulator, CORDIC vectoring unit and result staging.
// ----------------------------------------------------------------------------
module gtg_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [gtg_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic signed [gtg_pkg::POS_W-1:0]       req_fix_x,
   input  logic signed [gtg_pkg::POS_W-1:0]       req_fix_y,
   input  gtg_pkg::dp_cmd_type                    cmd,
   output gtg_pkg::dp_sts_type                    sts,
   output logic [gtg_pkg::CMD_W-1:0]              rsp_command,
   output logic signed [gtg_pkg::TURN_W-1:0]      rsp_turn_degrees,
   output logic [gtg_pkg::DUR_W-1:0]              rsp_duration_ms,
   output logic                                   rsp_arrived
);

   localparam logic [gtg_pkg::CSR_IDX_W-1:0] CSR_TARGET_X   = 3'd0;
   localparam logic [gtg_pkg::CSR_IDX_W-1:0] CSR_TARGET_Y   = 3'd1;
   localparam logic [gtg_pkg::CSR_IDX_W-1:0] CSR_ARRIVE     = 3'd2;
   localparam logic [gtg_pkg::CSR_IDX_W-1:0] CSR_HDG_MIN    = 3'd3;
   localparam logic [gtg_pkg::CSR_IDX_W-1:0] CSR_TURN_THR   = 3'd4;
   localparam logic [gtg_pkg::CSR_IDX_W-1:0] CSR_MS_DEG     = 3'd5;
   localparam logic [gtg_pkg::CSR_IDX_W-1:0] CSR_MS_CM      = 3'd6;
   localparam logic [gtg_pkg::CSR_IDX_W-1:0] CSR_STEP_CM    = 3'd7;

   localparam int DW = gtg_pkg::DIFF_W;
   localparam int CW = gtg_pkg::CW;
   localparam int ZW = gtg_pkg::ZW;
   localparam int AW = gtg_pkg::ACC_W;

   logic signed [gtg_pkg::POS_W-1:0] tgt_x_ff, tgt_y_ff;
   logic [11:0]                      arr_dist_ff, hdg_min_ff;
   logic [7:0]                       turn_thr_ff, ms_deg_ff, ms_cm_ff, step_cm_ff;

   logic signed [gtg_pkg::POS_W-1:0] old_x_ff, old_y_ff, cur_x_ff, cur_y_ff;
   logic signed [DW-1:0]             hdx_ff, hdy_ff, hdx_in, hdy_in;
   logic signed [DW-1:0]             mx, my, tx, ty;
   logic [12:0]                      hm;

   logic signed [DW-1:0]             op_a, op_b;
   logic signed [gtg_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic signed [AW-1:0]             prod_ext, acc_in, acc_ff, cross_ff;

   logic signed [CW-1:0]             cx_ff, cy_ff, cx_in, cy_in, xs, ys;
   logic signed [ZW-1:0]             cz_ff, cz_in, tab;
   logic [CW-1:0]                    ax, ay, m;

   logic [ZW-1:0]                    zmag;
   logic [9:0]                       zq;
   logic [7:0]                       zc, aa;
   logic signed [gtg_pkg::ANG_W-1:0] ang_ff, ang_in;
   logic [gtg_pkg::ANG_W-1:0]        ang_mag;

   gtg_pkg::out_cmd_type             res_cmd_ff, res_cmd_in;
   logic signed [gtg_pkg::TURN_W-1:0] res_turn_ff, res_turn_in;
   logic                             res_arr_ff, res_arr_in, res_zero_ff, res_zero_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_x_ff    <= '0;
         tgt_y_ff    <= '0;
         arr_dist_ff <= 12'd20;
         hdg_min_ff  <= 12'd20;
         turn_thr_ff <= 8'd10;
         ms_deg_ff   <= 8'd11;
         ms_cm_ff    <= 8'd30;
         step_cm_ff  <= 8'd10;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_X: tgt_x_ff    <= signed'(csr_wdata);
            CSR_TARGET_Y: tgt_y_ff    <= signed'(csr_wdata);
            CSR_ARRIVE:   arr_dist_ff <= csr_wdata[11:0];
            CSR_HDG_MIN:  hdg_min_ff  <= csr_wdata[11:0];
            CSR_TURN_THR: turn_thr_ff <= csr_wdata[7:0];
            CSR_MS_DEG:   ms_deg_ff   <= csr_wdata[7:0];
            CSR_MS_CM:    ms_cm_ff    <= csr_wdata[7:0];
            CSR_STEP_CM:  step_cm_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // position and heading
   assign mx = DW'(cur_x_ff) - DW'(old_x_ff);
   assign my = DW'(cur_y_ff) - DW'(old_y_ff);
   assign tx = DW'(tgt_x_ff) - DW'(cur_x_ff);
   assign ty = DW'(tgt_y_ff) - DW'(cur_y_ff);
   assign hm = 13'(hdg_min_ff) + 13'd1;

   always_comb begin
      hdx_in = hdx_ff;
      hdy_in = hdy_ff;
      if (cmd.heading_move && sts.far) begin
         hdx_in = mx;
         hdy_in = my;
      end else if (cmd.heading_tgt) begin
         hdx_in = tx;
         hdy_in = ty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         old_x_ff <= '0;
         old_y_ff <= '0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         hdx_ff   <= '0;
         hdy_ff   <= '0;
      end else begin
         if (cmd.capture) begin
            old_x_ff <= cur_x_ff;
            old_y_ff <= cur_y_ff;
            cur_x_ff <= req_fix_x;
            cur_y_ff <= req_fix_y;
         end
         hdx_ff <= hdx_in;
         hdy_ff <= hdy_in;
      end
   end

   // shared multiplier and accumulator
   always_comb begin
      case (cmd.mul_sel)
         gtg_pkg::MUL_MXMX:   begin op_a = mx;     op_b = mx;     end
         gtg_pkg::MUL_MYMY:   begin op_a = my;     op_b = my;     end
         gtg_pkg::MUL_HMHM:   begin
            op_a = signed'(DW'(hm));
            op_b = signed'(DW'(hm));
         end
         gtg_pkg::MUL_TXTX:   begin op_a = tx;     op_b = tx;     end
         gtg_pkg::MUL_TYTY:   begin op_a = ty;     op_b = ty;     end
         gtg_pkg::MUL_ADAD:   begin
            op_a = signed'(DW'(arr_dist_ff));
            op_b = signed'(DW'(arr_dist_ff));
         end
         gtg_pkg::MUL_HXTY:   begin op_a = hdx_ff; op_b = ty;     end
         gtg_pkg::MUL_HYTX:   begin op_a = hdy_ff; op_b = tx;     end
         gtg_pkg::MUL_HXTX:   begin op_a = hdx_ff; op_b = tx;     end
         gtg_pkg::MUL_HYTY:   begin op_a = hdy_ff; op_b = ty;     end
         gtg_pkg::MUL_ARRIVE: begin
            op_a = 17'sd360;
            op_b = signed'(DW'(ms_deg_ff));
         end
         gtg_pkg::MUL_STEP:   begin
            op_a = signed'(DW'(step_cm_ff));
            op_b = signed'(DW'(ms_cm_ff));
         end
         gtg_pkg::MUL_TURN:   begin
            op_a = signed'(DW'(aa));
            op_b = signed'(DW'(ms_deg_ff));
         end
         default:             begin op_a = '0;     op_b = '0;     end
      endcase
   end

   assign prod_in  = op_a * op_b;
   assign prod_ext = AW'(prod_ff);

   always_comb begin
      case (cmd.acc_op)
         gtg_pkg::ACC_LOAD: acc_in = prod_ext;
         gtg_pkg::ACC_ADD:  acc_in = acc_ff + prod_ext;
         gtg_pkg::ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:           acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_sel != gtg_pkg::MUL_NONE) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.cross_save) begin
         cross_ff <= acc_ff;
      end
   end

   assign sts.far      = acc_ff >= prod_ext;
   assign sts.near     = acc_ff < prod_ext;
   assign sts.vec_zero = (acc_ff == '0) && (cross_ff == '0);

   // CORDIC vectoring on (dot, cross)
   assign ax = cx_ff[CW-1] ? CW'(-cx_ff) : CW'(cx_ff);
   assign ay = cy_ff[CW-1] ? CW'(-cy_ff) : CW'(cy_ff);
   assign m  = (ax > ay) ? ax : ay;
   assign sts.norm_done = |m[CW-1:40];

   assign xs  = cx_ff >>> cmd.iter;
   assign ys  = cy_ff >>> cmd.iter;
   assign tab = signed'(ZW'(gtg_pkg::ATAN_Q16[cmd.iter]));

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      if (cmd.c_load) begin
         cx_in = CW'(acc_ff);
         cy_in = CW'(cross_ff);
         cz_in = '0;
      end else if (cmd.c_norm && !sts.norm_done) begin
         if (m[CW-1:32] == '0) begin
            cx_in = cx_ff <<< 8;
            cy_in = cy_ff <<< 8;
         end else begin
            cx_in = cx_ff <<< 1;
            cy_in = cy_ff <<< 1;
         end
      end else if (cmd.c_quad && cx_ff[CW-1]) begin
         if (!cy_ff[CW-1]) begin
            cx_in = cy_ff;
            cy_in = -cx_ff;
            cz_in = gtg_pkg::Z_QUARTER;
         end else begin
            cx_in = -cy_ff;
            cy_in = cx_ff;
            cz_in = -gtg_pkg::Z_QUARTER;
         end
      end else if (cmd.c_iter) begin
         if (!cy_ff[CW-1]) begin
            cx_in = cx_ff + ys;
            cy_in = cy_ff - xs;
            cz_in = cz_ff + tab;
         end else begin
            cx_in = cx_ff - ys;
            cy_in = cy_ff + xs;
            cz_in = cz_ff - tab;
         end
      end
   end

   // angle: truncate toward zero, clamp to +-180
   assign zmag = cz_ff[ZW-1] ? ZW'(-cz_ff) : ZW'(cz_ff);
   assign zq   = zmag[ZW-1:16];
   assign zc   = (zq > 10'd180) ? 8'd180 : zq[7:0];
   assign ang_in = cz_ff[ZW-1] ? -signed'(gtg_pkg::ANG_W'(zc))
                               : signed'(gtg_pkg::ANG_W'(zc));

   assign ang_mag = ang_ff[gtg_pkg::ANG_W-1] ? gtg_pkg::ANG_W'(-ang_ff)
                                             : gtg_pkg::ANG_W'(ang_ff);
   assign aa      = ang_mag[7:0];
   assign sts.turn_req = aa > turn_thr_ff;

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      if (cmd.angle_save) begin
         ang_ff <= ang_in;
      end
   end

   // result staging
   always_comb begin
      res_cmd_in  = res_cmd_ff;
      res_turn_in = res_turn_ff;
      res_arr_in  = res_arr_ff;
      res_zero_in = res_zero_ff;
      case (cmd.res_op)
         gtg_pkg::RES_FWD: begin
            res_cmd_in  = gtg_pkg::OUT_FWD;
            res_turn_in = '0;
            res_arr_in  = 1'b0;
            res_zero_in = 1'b0;
         end
         gtg_pkg::RES_TURN: begin
            res_cmd_in  = ang_ff[gtg_pkg::ANG_W-1] ? gtg_pkg::OUT_LEFT : gtg_pkg::OUT_RIGHT;
            res_turn_in = gtg_pkg::TURN_W'(ang_ff);
            res_arr_in  = 1'b0;
            res_zero_in = 1'b0;
         end
         gtg_pkg::RES_ARRIVE: begin
            res_cmd_in  = gtg_pkg::OUT_RIGHT;
            res_turn_in = 10'sd360;
            res_arr_in  = 1'b1;
            res_zero_in = 1'b0;
         end
         gtg_pkg::RES_HALT: begin
            res_cmd_in  = gtg_pkg::OUT_HALT;
            res_turn_in = '0;
            res_arr_in  = 1'b0;
            res_zero_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      res_cmd_ff  <= res_cmd_in;
      res_turn_ff <= res_turn_in;
      res_arr_ff  <= res_arr_in;
      res_zero_ff <= res_zero_in;
      if (cmd.out_load) begin
         rsp_command      <= res_cmd_ff;
         rsp_turn_degrees <= res_turn_ff;
         rsp_duration_ms  <= res_zero_ff ? '0 : prod_ff[gtg_pkg::DUR_W-1:0];
         rsp_arrived      <= res_arr_ff;
      end
   end

endmodule

[hw/rtl/gtg_ctrl.sv]
// ----------------------------------------------------------------------------
// gtg_ctrl
// Sequencer: phase tracking, micro-step state machine, CORDIC step counter
// and result valid flag.
// ----------------------------------------------------------------------------
module gtg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  gtg_pkg::dp_sts_type  sts,
   output gtg_pkg::dp_cmd_type  cmd
);

   gtg_pkg::state_type          state_ff, state_in;
   gtg_pkg::phase_type          phase_ff;
   logic [gtg_pkg::ITER_W-1:0]  iter_ff;
   logic                        rsp_valid_ff;
   logic                        accept;
   logic                        iter_last;

   assign req_ready = (state_ff == gtg_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign iter_last = (iter_ff == gtg_pkg::ITER_W'(gtg_pkg::CORDIC_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gtg_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (phase_ff)
                  gtg_pkg::PH_FIRST: state_in = gtg_pkg::ST_FIRST;
                  gtg_pkg::PH_RUN:   state_in = gtg_pkg::ST_M0;
                  default:           state_in = gtg_pkg::ST_FINISH;
               endcase
            end
         end
         gtg_pkg::ST_FIRST:  state_in = gtg_pkg::ST_FINISH;
         gtg_pkg::ST_M0:     state_in = gtg_pkg::ST_M1;
         gtg_pkg::ST_M1:     state_in = gtg_pkg::ST_M2;
         gtg_pkg::ST_M2:     state_in = gtg_pkg::ST_M3;
         gtg_pkg::ST_M3:     state_in = gtg_pkg::ST_M4;
         gtg_pkg::ST_M4:     state_in = gtg_pkg::ST_M5;
         gtg_pkg::ST_M5:     state_in = gtg_pkg::ST_M6;
         gtg_pkg::ST_M6:     state_in = sts.near ? gtg_pkg::ST_ARR : gtg_pkg::ST_X1;
         gtg_pkg::ST_ARR:    state_in = gtg_pkg::ST_FINISH;
         gtg_pkg::ST_X1:     state_in = gtg_pkg::ST_X2;
         gtg_pkg::ST_X2:     state_in = gtg_pkg::ST_X3;
         gtg_pkg::ST_X3:     state_in = gtg_pkg::ST_X4;
         gtg_pkg::ST_X4:     state_in = gtg_pkg::ST_CLOAD;
         gtg_pkg::ST_CLOAD:  state_in = sts.vec_zero ? gtg_pkg::ST_ANGLE : gtg_pkg::ST_NORM;
         gtg_pkg::ST_NORM: begin
            if (sts.norm_done) begin
               state_in = gtg_pkg::ST_QUAD;
            end
         end
         gtg_pkg::ST_QUAD:   state_in = gtg_pkg::ST_ITER;
         gtg_pkg::ST_ITER: begin
            if (iter_last) begin
               state_in = gtg_pkg::ST_ANGLE;
            end
         end
         gtg_pkg::ST_ANGLE:  state_in = gtg_pkg::ST_DECIDE;
         gtg_pkg::ST_DECIDE: state_in = gtg_pkg::ST_FINISH;
         gtg_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = gtg_pkg::ST_IDLE;
            end
         end
         default:            state_in = gtg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.capture      = 1'b0;
      cmd.mul_sel      = gtg_pkg::MUL_NONE;
      cmd.acc_op       = gtg_pkg::ACC_HOLD;
      cmd.heading_move = 1'b0;
      cmd.heading_tgt  = 1'b0;
      cmd.cross_save   = 1'b0;
      cmd.c_load       = 1'b0;
      cmd.c_norm       = 1'b0;
      cmd.c_quad       = 1'b0;
      cmd.c_iter       = 1'b0;
      cmd.iter         = iter_ff;
      cmd.angle_save   = 1'b0;
      cmd.res_op       = gtg_pkg::RES_HOLD;
      cmd.out_load     = 1'b0;
      case (state_ff)
         gtg_pkg::ST_IDLE: begin
            if (accept) begin
               if (phase_ff == gtg_pkg::PH_FIRST || phase_ff == gtg_pkg::PH_RUN) begin
                  cmd.capture = 1'b1;
               end else begin
                  cmd.res_op = gtg_pkg::RES_HALT;
               end
            end
         end
         gtg_pkg::ST_FIRST: begin
            cmd.mul_sel = gtg_pkg::MUL_STEP;
            cmd.res_op  = gtg_pkg::RES_FWD;
         end
         gtg_pkg::ST_M0: cmd.mul_sel = gtg_pkg::MUL_MXMX;
         gtg_pkg::ST_M1: begin
            cmd.mul_sel = gtg_pkg::MUL_MYMY;
            cmd.acc_op  = gtg_pkg::ACC_LOAD;
         end
         gtg_pkg::ST_M2: begin
            cmd.mul_sel = gtg_pkg::MUL_HMHM;
            cmd.acc_op  = gtg_pkg::ACC_ADD;
         end
         gtg_pkg::ST_M3: begin
            cmd.mul_sel      = gtg_pkg::MUL_TXTX;
            cmd.heading_move = 1'b1;
         end
         gtg_pkg::ST_M4: begin
            cmd.mul_sel = gtg_pkg::MUL_TYTY;
            cmd.acc_op  = gtg_pkg::ACC_LOAD;
         end
         gtg_pkg::ST_M5: begin
            cmd.mul_sel = gtg_pkg::MUL_ADAD;
            cmd.acc_op  = gtg_pkg::ACC_ADD;
         end
         gtg_pkg::ST_M6: cmd.mul_sel = gtg_pkg::MUL_HXTY;
         gtg_pkg::ST_ARR: begin
            cmd.mul_sel = gtg_pkg::MUL_ARRIVE;
            cmd.res_op  = gtg_pkg::RES_ARRIVE;
         end
         gtg_pkg::ST_X1: begin
            cmd.mul_sel = gtg_pkg::MUL_HYTX;
            cmd.acc_op  = gtg_pkg::ACC_LOAD;
         end
         gtg_pkg::ST_X2: begin
            cmd.mul_sel = gtg_pkg::MUL_HXTX;
            cmd.acc_op  = gtg_pkg::ACC_SUB;
         end
         gtg_pkg::ST_X3: begin
            cmd.mul_sel    = gtg_pkg::MUL_HYTY;
            cmd.acc_op     = gtg_pkg::ACC_LOAD;
            cmd.cross_save = 1'b1;
         end
         gtg_pkg::ST_X4:    cmd.acc_op     = gtg_pkg::ACC_ADD;
         gtg_pkg::ST_CLOAD: cmd.c_load     = 1'b1;
         gtg_pkg::ST_NORM:  cmd.c_norm     = 1'b1;
         gtg_pkg::ST_QUAD:  cmd.c_quad     = 1'b1;
         gtg_pkg::ST_ITER:  cmd.c_iter     = 1'b1;
         gtg_pkg::ST_ANGLE: cmd.angle_save = 1'b1;
         gtg_pkg::ST_DECIDE: begin
            if (sts.turn_req) begin
               cmd.mul_sel     = gtg_pkg::MUL_TURN;
               cmd.res_op      = gtg_pkg::RES_TURN;
               cmd.heading_tgt = 1'b1;
            end else begin
               cmd.mul_sel = gtg_pkg::MUL_STEP;
               cmd.res_op  = gtg_pkg::RES_FWD;
            end
         end
         gtg_pkg::ST_FINISH: cmd.out_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gtg_pkg::ST_IDLE;
         phase_ff     <= gtg_pkg::PH_FIRST;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && phase_ff == gtg_pkg::PH_FIRST) begin
            phase_ff <= gtg_pkg::PH_RUN;
         end else if (state_ff == gtg_pkg::ST_ARR) begin
            phase_ff <= gtg_pkg::PH_HALT;
         end
         if (state_ff == gtg_pkg::ST_QUAD) begin
            iter_ff <= '0;
         end else if (state_ff == gtg_pkg::ST_ITER) begin
            iter_ff <= iter_ff + 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == gtg_pkg::PH_HALT |=> phase_ff == gtg_pkg::PH_HALT)
      else $error("halted phase left");

   a_first_to_run: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == gtg_pkg::PH_FIRST |=> phase_ff == gtg_pkg::PH_RUN)
      else $error("first fix did not start run phase");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_load_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff && state_ff == gtg_pkg::ST_IDLE)
      else $error("result load did not return to idle with valid");
`endif

endmodule
